>>> src/flpd_pkg.sv
// ----------------------------------------------------------------------------
// flpd_pkg
// Types, constants and the coefficient ROM of the FIR low-pass / PWM block.
// ----------------------------------------------------------------------------
package flpd_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int COEF_W     = 16;   // signed Q1.15
  localparam int FRAC_BITS  = 15;
  localparam int PROD_W     = SAMPLE_W + 1 + COEF_W;
  localparam int ACC_W      = 40;
  localparam int PERIOD_W   = 16;
  localparam int DUTY_W     = 16;
  localparam int ROM_IDX_W  = 6;    // 64-entry ROM, taps past 26 are zero
  localparam int SCALED_W   = PERIOD_W + SAMPLE_W;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd2400;

  // x / 4095 == (x * ceil(2^42 / 4095)) >> 42, exact for x < 2^28
  localparam int                RECIP_W     = 31;
  localparam int                RECIP_SHIFT = 42;
  localparam logic [RECIP_W-1:0] DUTY_RECIP = 31'd1074004033;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_CLAMP,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } flpd_state_t;

  typedef struct packed {
    logic clear;
    logic tap_vld;
  } mac_ctl_t;

  typedef struct packed {
    logic clamp_en;
    logic mul_en;
    logic div_en;
  } scale_ctl_t;

  function automatic logic signed [COEF_W-1:0] coef_at(input logic [ROM_IDX_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    case (idx)
      6'd0, 6'd26:  c = 16'sd127;
      6'd2, 6'd24:  c = -16'sd259;
      6'd4, 6'd22:  c = 16'sd510;
      6'd5, 6'd21:  c = -16'sd1;
      6'd6, 6'd20:  c = -16'sd924;
      6'd7, 6'd19:  c = 16'sd1;
      6'd8, 6'd18:  c = 16'sd1645;
      6'd9, 6'd17:  c = -16'sd1;
      6'd10, 6'd16: c = -16'sd3197;
      6'd11, 6'd15: c = 16'sd1;
      6'd12, 6'd14: c = 16'sd10334;
      6'd13:        c = 16'sd16383;
      default:      c = '0;
    endcase
    return c;
  endfunction

endpackage

>>> src/flpd_delay_mem.sv
// ----------------------------------------------------------------------------
// flpd_delay_mem
// Sample delay line: one write port, one registered read port, per-entry
// valid bits so unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module flpd_delay_mem #(
  parameter int DEPTH = 27,
  parameter int AW    = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [flpd_pkg::SAMPLE_W-1:0] wr_data,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [flpd_pkg::SAMPLE_W-1:0] rd_data
);
  import flpd_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]    valid_r;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                rd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_hit_r ? rd_data_r : '0;

endmodule

>>> src/flpd_mac.sv
// ----------------------------------------------------------------------------
// flpd_mac
// Coefficient lookup, registered multiply and accumulate, one tap per beat
// of the read stream.
// ----------------------------------------------------------------------------
module flpd_mac #(
  parameter int TAP_W = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  flpd_pkg::mac_ctl_t                  ctl,
  input  logic [TAP_W-1:0]                    tap_idx,
  input  logic [flpd_pkg::SAMPLE_W-1:0]       rd_data,
  output logic signed [flpd_pkg::ACC_W-1:0]   acc,
  output logic                                busy
);
  import flpd_pkg::*;

  logic                      vld1_r;
  logic                      vld2_r;
  logic [TAP_W-1:0]          idx1_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [COEF_W-1:0]  coef;

  // tap index is registered to line up with the read data, the cycle after the address
  assign coef = coef_at(ROM_IDX_W'(idx1_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= ctl.tap_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= tap_idx;
    if (vld1_r) begin
      prod_r <= $signed({1'b0, rd_data}) * coef;
    end
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (vld2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign acc  = acc_r;
  // last product still in flight while vld1 is up; acc settles the next edge
  assign busy = vld1_r;

endmodule

>>> src/flpd_scale.sv
// ----------------------------------------------------------------------------
// flpd_scale
// Clamp of the accumulator to 0..4095, then duty = period * y / 4095 via
// a reciprocal multiply. Three register stages.
// ----------------------------------------------------------------------------
module flpd_scale (
  input  logic                                clk,
  input  flpd_pkg::scale_ctl_t                ctl,
  input  logic signed [flpd_pkg::ACC_W-1:0]   acc,
  input  logic [flpd_pkg::PERIOD_W-1:0]       period,
  output logic [flpd_pkg::SAMPLE_W-1:0]       filtered,
  output logic [flpd_pkg::DUTY_W-1:0]         duty
);
  import flpd_pkg::*;

  localparam int QF_W = SCALED_W + RECIP_W;

  logic [SAMPLE_W-1:0] y_r;
  logic [SAMPLE_W-1:0] y_nxt;
  logic [SCALED_W-1:0] p_r;
  logic [QF_W-1:0]     qf;
  logic [DUTY_W-1:0]   duty_r;

  always_comb begin
    if (acc[ACC_W-1]) begin
      y_nxt = '0;
    end else if (|acc[ACC_W-2:FRAC_BITS+SAMPLE_W]) begin
      y_nxt = '1;
    end else begin
      y_nxt = acc[FRAC_BITS +: SAMPLE_W];
    end
  end

  assign qf = p_r * DUTY_RECIP;

  always_ff @(posedge clk) begin
    if (ctl.clamp_en) begin
      y_r <= y_nxt;
    end
    if (ctl.mul_en) begin
      p_r <= period * y_r;
    end
    if (ctl.div_en) begin
      duty_r <= qf[RECIP_SHIFT +: DUTY_W];
    end
  end

  assign filtered = y_r;
  assign duty     = duty_r;

endmodule

>>> src/fir_lowpass_to_pwm_duty.sv
// ----------------------------------------------------------------------------
// fir_lowpass_to_pwm_duty
// 27-tap symmetric FIR low-pass on converter samples, scaled to a PWM width.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_sample): one 12-bit sample per
//   beat. Output channel (out_valid / out_stall / out_filtered / out_duty):
//   exactly one result beat per input beat, in order.
//   cfg_wr_en / cfg_wr_data write pwm_period; write only while idle.
// Timing:
//   One sample at a time. Each item passes from accept to the result register
//   through one delay-line read and one MAC per tap, a read/multiply drain,
//   then clamp, period multiply, reciprocal multiply and output load. The
//   next sample is accepted the cycle after the result loads.
// Reset:
//   Delay line reads as zero, write pointer at zero, pwm_period = 2400.
// Backpressure:
//   A finished result waits in the output register while out_stall is high;
//   the next sample may be accepted and filtered meanwhile, and holds in the
//   last stage until the output register frees up.
// ----------------------------------------------------------------------------
module fir_lowpass_to_pwm_duty #(
  parameter int TAPS = 27
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [flpd_pkg::SAMPLE_W-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [flpd_pkg::SAMPLE_W-1:0] out_filtered,
  output logic [flpd_pkg::DUTY_W-1:0]   out_duty,
  input  logic                          cfg_wr_en,
  input  logic [flpd_pkg::PERIOD_W-1:0] cfg_wr_data
);
  import flpd_pkg::*;

  localparam int TAP_W = $clog2(TAPS);
  localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(TAPS - 1);

  flpd_state_t state_r, state_nxt;

  logic [TAP_W-1:0]    wp_r, wp_nxt;
  logic [TAP_W-1:0]    rp_r, rp_nxt;
  logic [TAP_W-1:0]    k_r, k_nxt;
  logic [PERIOD_W-1:0] pwm_period_r;

  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_filtered_r;
  logic [DUTY_W-1:0]   out_duty_r;

  logic                accept;
  logic                rd_en;
  logic                out_load;
  mac_ctl_t            mac_ctl;
  scale_ctl_t          scale_ctl;
  logic                mac_busy;
  logic [SAMPLE_W-1:0] rd_data;
  logic signed [ACC_W-1:0] acc;
  logic [SAMPLE_W-1:0] filt;
  logic [DUTY_W-1:0]   duty;

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_RUN;
      ST_RUN:   if (k_r == LAST_TAP) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!mac_busy) state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_DIV;
      ST_DIV:   state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ---- outputs ----
  always_comb begin
    in_stall  = 1'b1;
    accept    = 1'b0;
    rd_en     = 1'b0;
    out_load  = 1'b0;
    mac_ctl   = '0;
    scale_ctl = '0;
    case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        accept        = in_valid;
        mac_ctl.clear = in_valid;
      end
      ST_RUN: begin
        rd_en           = 1'b1;
        mac_ctl.tap_vld = 1'b1;
      end
      ST_DRAIN: ;
      ST_CLAMP: scale_ctl.clamp_en = 1'b1;
      ST_MUL:   scale_ctl.mul_en   = 1'b1;
      ST_DIV:   scale_ctl.div_en   = 1'b1;
      ST_OUT:   out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  // ---- pointers ----
  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    k_nxt  = k_r;
    if (accept) begin
      wp_nxt = (wp_r == LAST_TAP) ? '0 : wp_r + 1'b1;
      rp_nxt = wp_r;                 // newest sample first
      k_nxt  = '0;
    end else if (rd_en) begin
      rp_nxt = (rp_r == '0) ? LAST_TAP : rp_r - 1'b1;
      k_nxt  = k_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      wp_r         <= '0;
      rp_r         <= '0;
      k_r          <= '0;
      pwm_period_r <= PERIOD_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      k_r     <= k_nxt;
      if (cfg_wr_en) begin
        pwm_period_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_filtered_r <= filt;
      out_duty_r     <= duty;
    end
  end

  // write and reads never overlap: the sample is written in the accept cycle,
  // reads start the cycle after
  flpd_delay_mem #(
    .DEPTH (TAPS),
    .AW    (TAP_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_addr (wp_r),
    .wr_data (in_sample),
    .rd_en   (rd_en),
    .rd_addr (rp_r),
    .rd_data (rd_data)
  );

  flpd_mac #(
    .TAP_W (TAP_W)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mac_ctl),
    .tap_idx (k_r),
    .rd_data (rd_data),
    .acc     (acc),
    .busy    (mac_busy)
  );

  flpd_scale u_scale (
    .clk      (clk),
    .ctl      (scale_ctl),
    .acc      (acc),
    .period   (pwm_period_r),
    .filtered (filt),
    .duty     (duty)
  );

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;
  assign out_duty     = out_duty_r;

  // ---- assertions ----
  a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_RUN))
    else $error("accepted beat did not start tap sweep");

  a_wp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r <= LAST_TAP) && (rp_r <= LAST_TAP))
    else $error("delay line pointer out of range");

  a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (k_r <= LAST_TAP))
    else $error("tap counter overran");

  a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_OUT))
    else $error("result loaded outside output state");

endmodule
